// ===== rtl/core/hrm_pkg.sv =====
// Shared types, codes and constant tables for the HDR radiance merge core.
package hrm_pkg;

   // Transaction action codes
   typedef enum logic [1:0] {
      ACT_CURVE    = 2'd0,
      ACT_EXPOSURE = 2'd1,
      ACT_PIXEL    = 2'd2
   } action_type;

   // Top-level sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_START,
      ST_FINISH
   } top_state_type;

   // Per-lane finish engine states
   typedef enum logic [2:0] {
      L_IDLE,
      L_DIV,
      L_MUL,
      L_RANGE,
      L_EXP,
      L_SCALE,
      L_DONE
   } lane_state_type;

   // Control from the sequencer to one lane
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic acc_en;
      logic start;
   } lane_ctrl_type;

   // Status from one lane to the sequencer and merge stage
   typedef struct packed {
      logic done;
      logic zero;
      logic sat;
   } lane_status_type;

   localparam int NUM_LANES = 3;

   // Entries in each response curve, one per byte value
   localparam int CURVE_ENTRIES = 256;

   // log2(e) in Q16
   localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

   typedef logic [31:0] factor_table_type [16];

   // Integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bit_m;
      logic [63:0] rem;
      r     = '0;
      bit_m = 64'h1 << 62;
      rem   = v;
      for (int k = 0; k < 32; k++) begin
         if (bit_m > rem) bit_m = bit_m >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bit_m != 64'd0) begin
            if (rem >= r + bit_m) begin
               rem = rem - (r + bit_m);
               r   = (r >> 1) + bit_m;
            end else begin
               r = r >> 1;
            end
            bit_m = bit_m >> 2;
         end
      end
      return r;
   endfunction

   // Q30 factors 2^(2^-i), i = 1..16, by repeated square roots of 2^31
   function automatic factor_table_type build_factor_table();
      factor_table_type tbl;
      logic [63:0] c;
      c = 64'h1 << 31;
      for (int i = 0; i < 16; i++) begin
         c      = isqrt64(c << 30);
         tbl[i] = c[31:0];
      end
      return tbl;
   endfunction

   localparam factor_table_type EXP_FACTOR = build_factor_table();

   // Hat weight: rises to 127, then falls to 0 at 255
   function automatic logic [7:0] hat_weight(logic [7:0] z);
      return (z <= 8'd127) ? z : 8'(8'd255 - z);
   endfunction

endpackage

// ===== rtl/core/hrm_if.sv =====
// Valid/ready channel interfaces for sample and radiance transactions.
interface hrm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [1:0]  curve_channel;
   logic [7:0]  table_index;
   logic signed [15:0] table_value;
   logic [3:0]  exposure_slot;
   logic [7:0]  red_byte;
   logic [7:0]  green_byte;
   logic [7:0]  blue_byte;
   logic        last_exposure;

   modport source (output valid, action, curve_channel, table_index, table_value,
                   exposure_slot, red_byte, green_byte, blue_byte, last_exposure,
                   input ready);
   modport sink (input valid, action, curve_channel, table_index, table_value,
                 exposure_slot, red_byte, green_byte, blue_byte, last_exposure,
                 output ready);
endinterface

interface hrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] red_radiance;
   logic [31:0] green_radiance;
   logic [31:0] blue_radiance;
   logic [2:0]  zero_weight_mask;
   logic [2:0]  saturated_mask;

   modport source (output valid, red_radiance, green_radiance, blue_radiance,
                   zero_weight_mask, saturated_mask, input ready);
   modport sink (input valid, red_radiance, green_radiance, blue_radiance,
                 zero_weight_mask, saturated_mask, output ready);
endinterface

// ===== rtl/core/hrm_lane.sv =====
// One color lane: response curve, weighted sums, divider and exp engine.
module hrm_lane
   import hrm_pkg::*;
#(
   parameter int LOG_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  lane_ctrl_type      ctrl,
   input  logic [7:0]         wr_addr,
   input  logic [15:0]        wr_data,
   input  logic [7:0]         rd_byte,
   input  logic signed [15:0] logexp,
   output lane_status_type    status,
   output logic [31:0]        radiance
);

   localparam int S  = LOG_FRAC_BITS + 16;
   localparam int TW = 51;

   // Response curve memory
   logic [15:0] curve_mem [CURVE_ENTRIES];
   logic [15:0] curve_rd_ff;
   logic [7:0]  weight_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) curve_mem[wr_addr] <= wr_data;
      if (ctrl.rd_en) begin
         curve_rd_ff <= curve_mem[rd_byte];
         weight_ff   <= hat_weight(rd_byte);
      end
   end

   // Weighted term of one sample
   logic signed [16:0] diff;
   logic signed [25:0] term;
   assign diff = $signed({curve_rd_ff[15], curve_rd_ff}) - $signed({logexp[15], logexp});
   assign term = $signed({1'b0, weight_ff}) * diff;

   lane_state_type state_ff, state_in;
   logic [31:0] num_ff;
   logic [11:0] den_ff;
   logic [11:0] dvs_ff;
   logic [11:0] rem_ff;
   logic [31:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic        neg_ff;
   logic signed [TW-1:0] t_ff;
   logic [31:0] acc_ff;
   logic [3:0]  step_ff;
   logic [31:0] result_ff;
   logic        zero_ff;
   logic        sat_ff;

   // Accumulators, cleared on reset and when a finish starts
   always_ff @(posedge clock) begin
      if (reset || ctrl.start) begin
         num_ff <= '0;
         den_ff <= '0;
      end else if (ctrl.acc_en) begin
         num_ff <= num_ff + {{6{term[25]}}, term};
         den_ff <= den_ff + {4'd0, weight_ff};
      end
   end

   // Divider trial subtract
   logic [12:0] trial;
   logic        qbit;
   assign trial = {rem_ff, quo_ff[31]};
   assign qbit  = (trial >= {1'b0, dvs_ff});

   // Signed mean and log2 scaling
   logic signed [32:0]   mean;
   logic signed [TW-1:0] t_in;
   logic signed [TW-1:0] ip_full;
   logic signed [5:0]    ip;
   logic [15:0]          f16;
   assign mean    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign t_in    = mean * LOG2E_Q16;
   assign ip_full = t_ff >>> S;
   assign ip      = ip_full[5:0];
   assign f16     = t_ff[S-1 -: 16];

   // Exp factor step
   logic [63:0] prod;
   logic [63:0] prod_rnd;
   assign prod     = {32'd0, acc_ff} * {32'd0, EXP_FACTOR[step_ff]};
   assign prod_rnd = (prod + (64'd1 << 29)) >> 30;

   // Final scaling to Q16.16
   logic [5:0]  sh;
   logic [47:0] r_dn;
   logic [32:0] r_up;
   logic        big;
   assign sh   = 6'(6'sd14 - ip);
   assign r_dn = (48'(acc_ff) + (48'd1 << (sh - 6'd1))) >> sh;
   assign r_up = {1'b0, acc_ff} << ip[0];
   assign big  = (ip >= 6'sd14) ? r_up[32] : 1'b0;

   // Finish datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         L_DIV: begin
            rem_ff <= qbit ? 12'(trial - {1'b0, dvs_ff}) : trial[11:0];
            quo_ff <= {quo_ff[30:0], qbit};
            cnt_ff <= cnt_ff + 5'd1;
         end
         L_MUL: t_ff <= t_in;
         L_RANGE: begin
            acc_ff  <= 32'h4000_0000;
            step_ff <= '0;
            if (ip_full >= 51'sd16) begin
               result_ff <= '1;
               sat_ff    <= 1'b1;
            end else if (ip_full < -51'sd32) begin
               result_ff <= '0;
            end
         end
         L_EXP: begin
            if (f16[~step_ff]) acc_ff <= prod_rnd[31:0];
            step_ff <= step_ff + 4'd1;
         end
         L_SCALE: begin
            if (big) begin
               result_ff <= '1;
               sat_ff    <= 1'b1;
            end else if (ip >= 6'sd14) begin
               result_ff <= r_up[31:0];
            end else begin
               result_ff <= r_dn[31:0];
            end
         end
         default: begin
            if (ctrl.start) begin
               zero_ff   <= (den_ff == 12'd0);
               sat_ff    <= 1'b0;
               result_ff <= '0;
               neg_ff    <= num_ff[31];
               dvs_ff    <= den_ff;
               rem_ff    <= '0;
               cnt_ff    <= '0;
               quo_ff    <= (num_ff[31] ? -num_ff : num_ff) + {21'd0, den_ff[11:1]};
            end
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= L_IDLE;
      else       state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         L_DIV:   if (cnt_ff == 5'd31) state_in = L_MUL;
         L_MUL:   state_in = L_RANGE;
         L_RANGE: begin
            if (ip_full >= 51'sd16 || ip_full < -51'sd32) state_in = L_DONE;
            else                                           state_in = L_EXP;
         end
         L_EXP:   if (step_ff == 4'd15) state_in = L_SCALE;
         L_SCALE: state_in = L_DONE;
         default: begin
            if (ctrl.start) state_in = (den_ff == 12'd0) ? L_DONE : L_DIV;
         end
      endcase
   end

   assign status.done = (state_ff == L_DONE);
   assign status.zero = zero_ff;
   assign status.sat  = sat_ff;
   assign radiance    = result_ff;

endmodule

// ===== rtl/core/hrm_merge.sv =====
// Merge stage: collects the three lane results into the output register.
module hrm_merge
   import hrm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  logic [31:0]     lane_rad [NUM_LANES],
   input  lane_status_type lane_stat [NUM_LANES],
   output logic            free,
   hrm_rsp_if.source       rsp_if
);

   logic        valid_ff;
   logic [31:0] red_ff, green_ff, blue_ff;
   logic [2:0]  zero_ff, sat_ff;

   // Output valid
   always_ff @(posedge clock) begin
      if (reset)               valid_ff <= 1'b0;
      else if (load)           valid_ff <= 1'b1;
      else if (rsp_if.ready)   valid_ff <= 1'b0;
   end

   // Pack lane results and flag masks
   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= lane_rad[0];
         green_ff <= lane_rad[1];
         blue_ff  <= lane_rad[2];
         zero_ff  <= {lane_stat[2].zero, lane_stat[1].zero, lane_stat[0].zero};
         sat_ff   <= {lane_stat[2].sat, lane_stat[1].sat, lane_stat[0].sat};
      end
   end

   assign free                    = !valid_ff || rsp_if.ready;
   assign rsp_if.valid            = valid_ff;
   assign rsp_if.red_radiance     = red_ff;
   assign rsp_if.green_radiance   = green_ff;
   assign rsp_if.blue_radiance    = blue_ff;
   assign rsp_if.zero_weight_mask = zero_ff;
   assign rsp_if.saturated_mask   = sat_ff;

endmodule

// ===== rtl/core/hdr_radiance_merge_core.sv =====
// Top level of the HDR radiance merge core: sequencer, exposure table, lanes.
//
//   channel   dir  handshake          carries
//   req_if    in   valid/ready        curve loads, exposure loads, pixel samples
//   rsp_if    out  valid/ready        RGB Q16.16 radiance, zero and saturation masks
//
// A load leaves the core idle; a pixel sample that is not last reads the curve, then adds.
// A last sample runs: accept, add, start, 32 bit-serial divider steps,
// multiply, range check, 16 exp factor steps, scaling and the output register load.
// A range exit skips exp and scaling; a lane whose weight sum is zero goes from start to done.
// Reset (synchronous) clears the sums and control; curves and exposure table are not cleared.
// A finished result waits in the output register; a new result stalls only while it is full.
module hdr_radiance_merge_core
   import hrm_pkg::*;
#(
   parameter int MAX_EXPOSURES = 16,
   parameter int LOG_FRAC_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   hrm_req_if.sink   req_if,
   hrm_rsp_if.source rsp_if
);

   localparam int LEW = (MAX_EXPOSURES > 1) ? $clog2(MAX_EXPOSURES) : 1;
   localparam int CW  = $clog2(CURVE_ENTRIES);

   top_state_type state_ff, state_in;
   logic accept;
   logic last_ff;
   logic merge_load;
   logic merge_free;
   logic all_done;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // Log exposure table
   logic [15:0]        exp_table [MAX_EXPOSURES];
   logic signed [15:0] logexp_ff;
   logic [LEW-1:0]     wr_idx, rd_idx;
   assign wr_idx = LEW'(req_if.table_index);
   assign rd_idx = LEW'(req_if.exposure_slot);

   always_ff @(posedge clock) begin
      if (accept && req_if.action == ACT_EXPOSURE &&
          32'(req_if.table_index) < MAX_EXPOSURES)
         exp_table[wr_idx] <= req_if.table_value;
      if (accept && req_if.action == ACT_PIXEL) begin
         logexp_ff <= (32'(req_if.exposure_slot) < MAX_EXPOSURES) ?
                      $signed(exp_table[rd_idx]) : 16'sd0;
         last_ff   <= req_if.last_exposure;
      end
   end

   // Lane controls
   lane_ctrl_type   ctrl [NUM_LANES];
   lane_status_type stat [NUM_LANES];
   logic [31:0]     rad  [NUM_LANES];
   logic [7:0]      bytes [NUM_LANES];
   assign bytes[0] = req_if.red_byte;
   assign bytes[1] = req_if.green_byte;
   assign bytes[2] = req_if.blue_byte;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      assign ctrl[g].wr_en  = accept && req_if.action == ACT_CURVE &&
                              req_if.curve_channel == 2'(g);
      assign ctrl[g].rd_en  = accept && req_if.action == ACT_PIXEL;
      assign ctrl[g].acc_en = (state_ff == ST_ACC);
      assign ctrl[g].start  = (state_ff == ST_START);

      hrm_lane #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl[g]),
         .wr_addr  (8'(req_if.table_index[CW-1:0])),
         .wr_data  (req_if.table_value),
         .rd_byte  (bytes[g]),
         .logexp   (logexp_ff),
         .status   (stat[g]),
         .radiance (rad[g])
      );
   end

   assign all_done = stat[0].done && stat[1].done && stat[2].done;

   // Merge stage
   hrm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (merge_load),
      .lane_rad  (rad),
      .lane_stat (stat),
      .free      (merge_free),
      .rsp_if    (rsp_if)
   );

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      merge_load = 1'b0;
      case (state_ff)
         ST_IDLE:  if (accept && req_if.action == ACT_PIXEL) state_in = ST_ACC;
         ST_ACC:   state_in = last_ff ? ST_START : ST_IDLE;
         ST_START: state_in = ST_FINISH;
         ST_FINISH: begin
            if (all_done && merge_free) begin
               merge_load = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Checks
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      merge_load |-> all_done)
      else $error("result captured before all lanes finished");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      merge_load |-> merge_free)
      else $error("output register overwritten");
   a_pixel_acc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.action == ACT_PIXEL) |=> state_ff == ST_ACC)
      else $error("pixel transaction not accumulated");
   a_start_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |=> (state_ff == ST_FINISH && $past(last_ff)))
      else $error("finish sequence broken");

endmodule
